[sv/mav_pkg.sv]
package mav_pkg;

	// default sizes
	localparam int WINDOW_MAX_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int SUM_W = 24;
	localparam int AVG_W = 16;
	localparam int CFG_W = 9;
	localparam int OUT_W = ((SUM_W + AVG_W + 7) / 8) * 8;

	// window size after reset
	localparam logic [CFG_W-1:0] WS_RESET = CFG_W'(16);

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

[sv/moving_average_filter_top.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  s_axis_tdata: sample
// m_axis    out  m_axis_tvalid/m_axis_tready  m_axis_tdata: window_sum, window_average
// cfg       in   cfg_wr_en                    cfg_wr_data: window_size
//
// Each word passes through ring read, accumulate and write-back, 24 steps of the
// bit-serial divider, and a load into the output register. The divider sets the rate.
// A new word is taken while the previous result still sits in the output register.
// Reset clears the sum, the write index and the ring (an entry counts as zero until
// the index has wrapped once); a window size write does the same at once.
// A stalled output holds the finished result in the done state until it is taken.
module moving_average_filter_top
	import mav_pkg::*;
#(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [OUT_W-1:0]                    m_axis_tdata,  // window_sum, window_average
	input  logic                                cfg_wr_en,
	input  logic [CFG_W-1:0]                    cfg_wr_data    // window_size
);

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int EFF_W = $clog2(WINDOW_MAX + 1);
	localparam int CNT_W = $clog2(SUM_W);

	// clamp window size to 1..WINDOW_MAX
	function automatic logic [EFF_W-1:0] eff_of(input logic [CFG_W-1:0] ws);
		logic [EFF_W-1:0] r;
		if (ws == '0) begin
			r = EFF_W'(1);
		end else if (32'(ws) > 32'(WINDOW_MAX)) begin
			r = EFF_W'(WINDOW_MAX);
		end else begin
			r = EFF_W'(ws);
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic [EFF_W-1:0]       eff_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   wrapped_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   neg_q;
	logic [SUM_W-1:0]       quo_q;
	logic [EFF_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_data_q;

	logic                   in_take;
	logic                   out_load;
	logic                   ram_rd_en;
	logic                   ram_wr_en;
	logic                   div_step;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       new_sum;
	logic [SUM_W-1:0]       new_mag;
	logic [IDX_W:0]         idx_inc;
	logic                   idx_wrap;
	logic [EFF_W:0]         rem_sh;
	logic                   quo_bit;
	logic [SUM_W-1:0]       quo_signed;
	logic [AVG_W-1:0]       avg;

	// ring store
	mav_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(idx_q),
		.wr_data(sample_q),
		.rd_en  (ram_rd_en),
		.rd_addr(idx_q),
		.rd_data(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		ram_wr_en     = 1'b0;
		div_step      = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_ACC:  ram_wr_en     = 1'b1;
			ST_DIV:  div_step      = 1'b1;
			ST_DONE: out_load      = !out_valid_q || m_axis_tready;
			default: s_axis_tready = 1'b0;
		endcase
	end

	assign in_take   = s_axis_tvalid && s_axis_tready;
	assign ram_rd_en = in_take;

	// accumulate: unwritten ring entries read as zero
	assign old_sample = wrapped_q ? ram_rdata : '0;
	assign new_sum    = sum_q + SUM_W'($signed(sample_q)) - SUM_W'($signed(old_sample));
	assign new_mag    = new_sum[SUM_W-1] ? (~new_sum + SUM_W'(1)) : new_sum;
	assign idx_inc    = {1'b0, idx_q} + (IDX_W+1)'(1);
	assign idx_wrap   = 32'(idx_inc) >= 32'(eff_q);

	// restoring divider step
	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign quo_bit = rem_sh >= {1'b0, eff_q};

	// sign of quotient follows the sum
	assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	assign avg        = quo_signed[AVG_W-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eff_q       <= eff_of(WS_RESET);
			idx_q       <= '0;
			wrapped_q   <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				eff_q     <= eff_of(cfg_wr_data);
				idx_q     <= '0;
				wrapped_q <= 1'b0;
				sum_q     <= '0;
			end else if (ram_wr_en) begin
				sum_q <= new_sum;
				if (idx_wrap) begin
					idx_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					idx_q <= idx_inc[IDX_W-1:0];
				end
			end
			if (ram_wr_en) begin
				cnt_q <= CNT_W'(SUM_W - 1);
			end else if (div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		if (ram_wr_en) begin
			neg_q <= new_sum[SUM_W-1];
			quo_q <= new_mag;
			rem_q <= '0;
		end else if (div_step) begin
			rem_q <= quo_bit ? EFF_W'(rem_sh - {1'b0, eff_q}) : EFF_W'(rem_sh);
			quo_q <= {quo_q[SUM_W-2:0], quo_bit};
		end
		if (out_load) begin
			out_data_q <= OUT_W'({avg, sum_q});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[sv/mav_ram.sv]
module mav_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/mav_checker.sv]
module mav_checker
	import mav_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// result word holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// one word in flight: input closes right after a take
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word taken while one is in flight");

	// truncated average never has the opposite sign of the sum
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[SUM_W+AVG_W-1:SUM_W] == '0) ||
			(m_axis_tdata[SUM_W+AVG_W-1] == m_axis_tdata[SUM_W-1]))
		else $error("average sign disagrees with sum");

endmodule

bind moving_average_filter_top mav_checker u_mav_checker (.*);

[tb/moving_average_filter_top_tb.sv]
`timescale 1ns / 1ps

module moving_average_filter_top_tb;
	import mav_pkg::*;

	localparam int RING_DEPTH = WINDOW_MAX_DEF;
	localparam int IN_W       = ((SAMPLE_BITS_DEF + 7) / 8) * 8;

	// one expected output word
	typedef struct {
		logic [SUM_W-1:0] sum;
		logic [AVG_W-1:0] avg;
	} avg_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;     // sample
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;          // window_sum, window_average
	logic              cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data = '0;      // window_size

	// predictor state
	logic signed [15:0] ring_copy [RING_DEPTH];
	int                 slot_ptr;
	int                 win_len;
	logic [SUM_W-1:0]   sum_acc;
	avg_word_t          pending_results [$];

	int err_count  = 0;
	int burst_left = 0;

	// receiver stall pattern
	int rx_mode      = 0;
	int rx_mode_left = 0;
	int rx_hold      = 0;

	moving_average_filter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// window size write clears ring, sum and index; 0 acts as 1, above max saturates
	function automatic void window_clear(logic [CFG_W-1:0] ws);
		win_len = (ws == 0) ? 1 : ((ws > RING_DEPTH) ? RING_DEPTH : int'(ws));
		foreach (ring_copy[i])
			ring_copy[i] = '0;
		slot_ptr = 0;
		sum_acc  = '0;
	endfunction

	// running sum update and truncating divide for one accepted sample
	function automatic void predict_average(logic signed [15:0] fresh);
		logic signed [15:0] old;
		avg_word_t          w;
		int                 quot;
		if (slot_ptr >= win_len)
			slot_ptr = 0;
		old     = ring_copy[slot_ptr];
		sum_acc = sum_acc + {{8{fresh[15]}}, fresh} - {{8{old[15]}}, old};
		quot    = int'($signed(sum_acc)) / win_len;
		ring_copy[slot_ptr] = fresh;
		slot_ptr = slot_ptr + 1;
		if (slot_ptr >= win_len)
			slot_ptr = 0;
		w.sum = sum_acc;
		w.avg = quot[AVG_W-1:0];
		pending_results.push_back(w);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// output checker
	always @(posedge clk) begin
		avg_word_t w;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, sum", $signed(m_axis_tdata[SUM_W-1:0]), 0);
			end else begin
				w = pending_results.pop_front();
				if (m_axis_tdata[SUM_W-1:0] !== w.sum)
					report_mismatch("window_sum", $signed(m_axis_tdata[SUM_W-1:0]),
						$signed(w.sum));
				if (m_axis_tdata[SUM_W+AVG_W-1:SUM_W] !== w.avg)
					report_mismatch("window_average",
						$signed(m_axis_tdata[SUM_W+AVG_W-1:SUM_W]), $signed(w.avg));
			end
		end
	end

	// receiver: switches between always ready, random ready and long stalls
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= $urandom_range(0, 2);
			rx_mode_left <= $urandom_range(64, 512);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (rx_hold == 0) begin
					m_axis_tready <= ~m_axis_tready;
					rx_hold       <= $urandom_range(1, 40);
				end else begin
					rx_hold <= rx_hold - 1;
				end
			end
		endcase
	end

	// send one word; valid stays high for the caller to reuse or drop
	task automatic send_sample(logic signed [15:0] s);
		s_axis_tdata  <= IN_W'(s);
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		predict_average(s);
	endtask

	// sender bursts with random gaps
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 24);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off input until every expected word has come out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic set_window(logic [CFG_W-1:0] ws);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ws;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		window_clear(ws);
	endtask

	function automatic logic [15:0] pick_sample(int bias);
		int r;
		r = $urandom_range(0, 9);
		if (bias != 0 && r < 5)
			return (bias > 0) ? 16'($urandom_range(24000, 32767))
				: 16'(-$urandom_range(24000, 32768));
		if (r < 7)
			return 16'($urandom);
		if (r < 9) begin
			case ($urandom_range(0, 3))
				0: return 16'h7fff;
				1: return 16'h8000;
				2: return 16'h0000;
				default: return 16'hffff;
			endcase
		end
		return 16'($urandom_range(0, 200) - 100);
	endfunction

	// sample extremes at the reset window size
	task automatic test_default_window();
		logic [15:0] vals [10] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001,
			16'h5555, 16'haaaa, 16'h7fff, 16'h7fff, 16'h8000};
		foreach (vals[i]) begin
			send_sample(vals[i]);
			pace_sender();
		end
	endtask

	// zero window, single slot, saturated sizes, two slots
	task automatic test_window_limits();
		set_window(CFG_W'(0));
		send_sample(16'h7fff);
		send_sample(16'h8000);
		send_sample(16'hffff);
		set_window(CFG_W'(1));
		send_sample(16'h8000);
		send_sample(16'h0003);
		set_window(CFG_W'(511));
		send_sample(16'h7fff);
		send_sample(16'h8000);
		set_window(CFG_W'(257));
		send_sample(16'h7fff);
		send_sample(16'hfffd);
		set_window(CFG_W'(2));
		send_sample(16'h8000);
		send_sample(16'h8000);
		send_sample(16'h7fff);
	endtask

	// fill the largest window to both ends of the sum range
	task automatic test_full_scale();
		set_window(CFG_W'(RING_DEPTH));
		repeat (260) begin
			send_sample(16'h7fff);
			pace_sender();
		end
		drain_results();
		repeat (260) begin
			send_sample(16'h8000);
			pace_sender();
		end
	endtask

	// random window sizes, each with a run of random samples
	task automatic test_random_windows(int target);
		int sent;
		int run_len;
		int bias;
		logic [CFG_W-1:0] ws;
		logic [CFG_W-1:0] edge_sizes [7] = '{0, 1, 2, 255, 256, 257, 511};
		sent = 0;
		while (sent < target) begin
			ws = ($urandom_range(0, 3) == 0) ? edge_sizes[$urandom_range(0, 6)]
				: CFG_W'($urandom_range(0, 511));
			set_window(ws);
			run_len = $urandom_range(1, (ws > 140) ? 300 : 2 * int'(ws) + 8);
			if (run_len > target - sent)
				run_len = target - sent;
			bias = $urandom_range(0, 2) - 1;
			repeat (run_len) begin
				send_sample(pick_sample(bias));
				sent++;
				if ($urandom_range(0, 49) == 0)
					drain_results();
				else
					pace_sender();
			end
		end
	endtask

	initial begin
		window_clear(WS_RESET);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_window_limits();
		test_full_scale();
		test_random_windows(1080);

		drain_results();
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[moving_average_filter_top.f]
sv/mav_pkg.sv
sv/mav_ram.sv
sv/moving_average_filter_top.sv
sv/mav_checker.sv
tb/moving_average_filter_top_tb.sv
